// ===== rtl/hid_report_fragmenter_core_macros.svh =====
// Assertion macros used by the checker of the report fragmenter.
`ifndef HID_REPORT_FRAGMENTER_CORE_MACROS_SVH
`define HID_REPORT_FRAGMENTER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HRF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hrf: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define HRF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hrf: next-cycle check failed");

`endif

// ===== rtl/hrf_pkg.sv =====
`default_nettype none

package hrf_pkg;

  localparam int unsigned HdrFirstBit = 6;
  localparam int unsigned HdrLastBit  = 7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] msg_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] report_byte;
    logic       report_end;
    logic       message_end;
  } out_item_t;

  typedef struct packed {
    logic hdr;
    logic dat_in;
    logic dat_held;
    logic pad;
  } hrf_cmd_t;

  typedef struct packed {
    logic out_free;
    logic frem_zero;
    logic needs_pad;
    logic pad_last;
  } hrf_sts_t;

endpackage

`default_nettype wire

// ===== rtl/hrf_datapath.sv =====
`default_nettype none

module hrf_datapath #(
  parameter int unsigned MAX_MESSAGE = 255,
  parameter int unsigned REPORT_SIZE = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire hrf_pkg::in_item_t in_item_i,
  input  wire hrf_pkg::hrf_cmd_t cmd_i,
  input  wire logic              out_stall_i,
  output hrf_pkg::hrf_sts_t      sts_o,
  output logic                   out_valid_o,
  output hrf_pkg::out_item_t     out_item_o
);
  import hrf_pkg::*;

  localparam logic [5:0] Span   = 6'(REPORT_SIZE - 1);
  localparam logic [7:0] MaxLen = 8'(MAX_MESSAGE);

  logic [7:0] pos_q, latched_q;
  logic [5:0] frem_q, pay_q, pad_cnt_q;
  logic       final_q, out_valid_q;
  logic [7:0] data_q;
  out_item_t  out_q;

  logic [7:0] len_sat, len_lat, rest, hdr_byte, dat;
  logic [5:0] pay, pad_len;
  logic       last, first, close, needs_pad, pad_last, emit_dat, emit;

  always_comb begin
    if (in_item_i.msg_length == 8'd0) begin
      len_sat = 8'd1;
    end else if (in_item_i.msg_length > MaxLen) begin
      len_sat = MaxLen;
    end else begin
      len_sat = in_item_i.msg_length;
    end
    first    = (pos_q == 8'd0);
    len_lat  = first ? len_sat : latched_q;
    rest     = len_lat - pos_q;
    last     = (rest <= {2'b00, Span});
    pay      = last ? rest[5:0] : Span;
    hdr_byte = {2'b00, pay};
    hdr_byte[HdrFirstBit] = first;
    hdr_byte[HdrLastBit]  = last;
    dat       = cmd_i.dat_in ? in_item_i.data_byte : data_q;
    close     = (frem_q == 6'd1);
    pad_len   = Span - pay_q;
    needs_pad = close && final_q && (pad_len != 6'd0);
    pad_last  = (pad_cnt_q == 6'd1);
    emit_dat  = cmd_i.dat_in || cmd_i.dat_held;
    emit      = cmd_i.hdr || emit_dat || cmd_i.pad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= 8'd0;
      latched_q   <= 8'd0;
      frem_q      <= 6'd0;
      final_q     <= 1'b0;
      pad_cnt_q   <= 6'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.hdr) begin
        latched_q <= len_lat;
        frem_q    <= pay;
        final_q   <= last;
      end else if (emit_dat) begin
        frem_q <= frem_q - 6'd1;
        if (close && final_q) begin
          pos_q   <= 8'd0;
          final_q <= 1'b0;
        end else begin
          pos_q <= pos_q + 8'd1;
        end
        if (needs_pad) begin
          pad_cnt_q <= pad_len;
        end
      end else if (cmd_i.pad) begin
        pad_cnt_q <= pad_cnt_q - 6'd1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hdr) begin
      data_q <= in_item_i.data_byte;
      pay_q  <= pay;
      out_q  <= '{report_byte: hdr_byte, report_end: 1'b0, message_end: 1'b0};
    end else if (emit_dat) begin
      out_q <= '{report_byte: dat,
                 report_end:  close && !needs_pad,
                 message_end: close && final_q && !needs_pad};
    end else if (cmd_i.pad) begin
      out_q <= '{report_byte: 8'd0, report_end: pad_last, message_end: pad_last};
    end
  end

  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign sts_o.frem_zero = (frem_q == 6'd0);
  assign sts_o.needs_pad = needs_pad;
  assign sts_o.pad_last  = pad_last;
  assign out_valid_o     = out_valid_q;
  assign out_item_o      = out_q;

endmodule

`default_nettype wire

// ===== rtl/hrf_ctrl.sv =====
`default_nettype none

module hrf_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire hrf_pkg::hrf_sts_t sts_i,
  output logic                   in_stall_o,
  output hrf_pkg::hrf_cmd_t      cmd_o
);
  import hrf_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StData,
    StPad
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  always_comb begin
    accept  = (state_q == StIdle) && in_valid_i && sts_i.out_free;
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (sts_i.frem_zero) begin
            cmd_o.hdr = 1'b1;
            state_d   = StData;
          end else begin
            cmd_o.dat_in = 1'b1;
            if (sts_i.needs_pad) begin
              state_d = StPad;
            end
          end
        end
      end
      StData: begin
        if (sts_i.out_free) begin
          cmd_o.dat_held = 1'b1;
          state_d = sts_i.needs_pad ? StPad : StIdle;
        end
      end
      StPad: begin
        if (sts_i.out_free) begin
          cmd_o.pad = 1'b1;
          if (sts_i.pad_last) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = !((state_q == StIdle) && sts_i.out_free);

endmodule

`default_nettype wire

// ===== rtl/hid_report_fragmenter_core.sv =====
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_stall_o  in_item_i  (data_byte, msg_length)
// out      output     out_valid_o / out_stall_i out_item_o (report_byte, report_end,
//                                                           message_end)
//
// A byte in the middle of a report makes one transfer; one that opens a report makes two,
// the header transfer and then the byte itself.
// A byte that closes a message's last report is followed by REPORT_SIZE - 1 - payload pad
// transfers, one per cycle unless the output stalls, as the single output register sets.
// Reset is asynchronous and active low, and leaves the block at the start of a message.
// A stalled output holds its transfer and stalls the input until it is taken.
`default_nettype none

module hid_report_fragmenter_core #(
  parameter int unsigned MAX_MESSAGE = 255,
  parameter int unsigned REPORT_SIZE = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire hrf_pkg::in_item_t in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output hrf_pkg::out_item_t     out_item_o
);
  import hrf_pkg::*;

  hrf_cmd_t cmd;
  hrf_sts_t sts;

  hrf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  hrf_datapath #(
    .MAX_MESSAGE (MAX_MESSAGE),
    .REPORT_SIZE (REPORT_SIZE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .out_stall_i (out_stall_i),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ===== rtl/hrf_checker.sv =====
`default_nettype none
`include "hid_report_fragmenter_core_macros.svh"

module hrf_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire hrf_pkg::out_item_t out_item_o
);
  import hrf_pkg::*;

  `HRF_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o))
  `HRF_ASSERT_SAME(a_msg_end_on_report_end, out_valid_o && out_item_o.message_end, out_item_o.report_end)
  `HRF_ASSERT_NEXT(a_accept_gives_output, in_valid_i && !in_stall_o, out_valid_o)
  `HRF_ASSERT_SAME(a_stall_back, out_valid_o && out_stall_i, in_stall_o)

endmodule

bind hid_report_fragmenter_core hrf_checker u_hrf_checker (.*);

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import hrf_pkg::*;

  localparam int ReportSize = 64;
  localparam int ReportSpan = ReportSize - 1;
  localparam int RandomItems = 41;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  bit idle_enable;
  bit stall_enable;

  // Mirror of the fragmenter state, advanced once per accepted input byte.
  logic [7:0] msg_pos;
  logic [7:0] latched_len;
  logic [5:0] frag_rem;
  bit         frag_final;

  out_item_t report_bytes_due[$];

  int items_accepted;
  int bytes_checked;
  int reports_checked;
  int messages_checked;
  int mismatch_count;

  hid_report_fragmenter_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= stall_enable && ($urandom_range(99) < 10);
    end
  end

  task automatic push_report_byte(input logic [7:0] value, input bit rep_end,
                                  input bit msg_end);
    out_item_t rb;
    rb.report_byte = value;
    rb.report_end  = rep_end;
    rb.message_end = msg_end;
    report_bytes_due.push_back(rb);
  endtask

  task automatic predict_report_bytes(input in_item_t item);
    logic [7:0] rest;
    logic [7:0] hdr;
    logic [5:0] payload;
    bit         last;
    bit         closes;
    int         pad_count;
    if (msg_pos == 8'd0 && frag_rem == 6'd0) begin
      latched_len = (item.msg_length == 8'd0) ? 8'd1 : item.msg_length;
    end
    if (frag_rem == 6'd0) begin
      rest    = latched_len - msg_pos;
      last    = (rest <= ReportSpan);
      payload = last ? rest[5:0] : 6'(ReportSpan);
      hdr     = {2'b00, payload};
      hdr[HdrFirstBit] = (msg_pos == 8'd0);
      hdr[HdrLastBit]  = last;
      push_report_byte(hdr, 1'b0, 1'b0);
      frag_rem   = payload;
      frag_final = last;
    end
    msg_pos   = msg_pos + 8'd1;
    frag_rem  = frag_rem - 6'd1;
    closes    = (frag_rem == 6'd0);
    pad_count = 0;
    if (closes && frag_final) begin
      pad_count = ReportSpan - ((int'(latched_len) - 1) % ReportSpan + 1);
    end
    push_report_byte(item.data_byte, closes && pad_count == 0,
                     closes && frag_final && pad_count == 0);
    for (int i = 0; i < pad_count; i++) begin
      push_report_byte(8'h00, i == pad_count - 1, i == pad_count - 1);
    end
    if (closes && frag_final) begin
      msg_pos    = 8'd0;
      frag_final = 1'b0;
    end
  endtask

  task automatic check_report_byte(input out_item_t got);
    out_item_t want;
    if (report_bytes_due.size() == 0) begin
      $error("unexpected transfer: report_byte %0h report_end %0b message_end %0b",
             got.report_byte, got.report_end, got.message_end);
      mismatch_count++;
    end else begin
      want = report_bytes_due.pop_front();
      if (got.report_byte !== want.report_byte) begin
        $error("report_byte: expected %0h, got %0h", want.report_byte, got.report_byte);
        mismatch_count++;
      end
      if (got.report_end !== want.report_end) begin
        $error("report_end: expected %0b, got %0b", want.report_end, got.report_end);
        mismatch_count++;
      end
      if (got.message_end !== want.message_end) begin
        $error("message_end: expected %0b, got %0b", want.message_end, got.message_end);
        mismatch_count++;
      end
    end
    bytes_checked++;
    if (got.report_end === 1'b1) reports_checked++;
    if (got.message_end === 1'b1) messages_checked++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_report_bytes(in_item);
        items_accepted++;
      end
      if (out_valid && !out_stall) begin
        check_report_byte(out_item);
      end
    end
  end

  task automatic send_byte(input logic [7:0] data, input logic [7:0] len);
    int target;
    while (idle_enable && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid             <= 1'b1;
    in_item.data_byte    <= data;
    in_item.msg_length   <= len;
    target = items_accepted + 1;
    do @(negedge clk); while (items_accepted < target);
  endtask

  task automatic send_message(input logic [7:0] len_field);
    int total;
    total = (len_field == 8'd0) ? 1 : int'(len_field);
    send_byte(8'($urandom_range(255)), len_field);
    for (int i = 1; i < total; i++) begin
      send_byte(8'($urandom_range(255)), 8'($urandom_range(255)));
    end
  endtask

  // A zero length is taken as a one-byte message.
  task automatic test_single_byte_messages();
    send_byte(8'h00, 8'd0);
    send_byte(8'hFF, 8'd1);
    send_byte(8'hFF, 8'd0);
    send_byte(8'h00, 8'd1);
  endtask

  // Only the length sampled with the first byte of a message counts.
  task automatic test_length_change_ignored();
    send_byte(8'h5A, 8'd3);
    send_byte(8'hA5, 8'd0);
    send_byte(8'hFF, 8'hFF);
    send_byte(8'h80, 8'd2);
    send_byte(8'h7F, 8'd1);
    send_byte(8'h01, 8'd3);
    send_byte(8'hFE, 8'd128);
    send_byte(8'h00, 8'd0);
  endtask

  // Both messages run with no idling on either side.
  task automatic test_fragment_boundaries();
    idle_enable  = 1'b0;
    stall_enable = 1'b0;
    send_message(8'd63);
    send_message(8'd64);
    idle_enable  = 1'b1;
    stall_enable = 1'b1;
  endtask

  task automatic test_random_traffic();
    int start_items;
    int sent;
    int budget;
    int pick;
    logic [7:0] len;
    start_items = items_accepted;
    sent = 0;
    while (sent < RandomItems) begin
      budget = RandomItems - sent;
      pick = $urandom_range(99);
      if (pick < 15) begin
        len = 8'd0;
      end else begin
        len = 8'($urandom_range(1, 24));
      end
      if (int'(len) > budget) begin
        len = 8'(budget);
      end
      send_message(len);
      sent = items_accepted - start_items;
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_item      = '0;
    idle_enable  = 1'b1;
    stall_enable = 1'b1;
    msg_pos      = '0;
    latched_len  = '0;
    frag_rem     = '0;
    frag_final   = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_single_byte_messages();
    test_length_change_ignored();
    test_fragment_boundaries();
    test_random_traffic();

    in_valid <= 1'b0;
    while (report_bytes_due.size() != 0) @(negedge clk);
    repeat (2 * ReportSize) @(negedge clk);

    $display("Sent %0d message bytes; checked %0d report bytes in %0d reports.",
             items_accepted, bytes_checked, reports_checked);
    $display("Covered %0d complete messages, from one byte up to two reports long.",
             messages_checked);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
